// ===== sv/sct_pkg.sv =====
package sct_pkg;

  // Width of each impedance part on the input channel (Q16.16 by default).
  localparam int SAMPLE_WIDTH = 32;
  // Width of every result part on the output channel.
  localparam int OUT_WIDTH = 32;
  // Number of quotient bits each divider lane develops.
  localparam int QUOT_BITS = 32;

  localparam logic signed [OUT_WIDTH-1:0] SAT_POS = {1'b0, {(OUT_WIDTH-1){1'b1}}};
  localparam logic signed [OUT_WIDTH-1:0] SAT_NEG = {1'b1, {(OUT_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] z_real;
    logic signed [SAMPLE_WIDTH-1:0] z_imag;
    logic                           last_sample;
  } sct_in_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] gamma_real;
    logic signed [OUT_WIDTH-1:0] gamma_imag;
    logic signed [OUT_WIDTH-1:0] low_extreme;
    logic signed [OUT_WIDTH-1:0] high_extreme;
    logic                        singular;
    logic                        end_of_vector;
  } sct_out_t;

  // Control of a serial arithmetic lane: load new operands, or take one step.
  typedef struct packed {
    logic load;
    logic step;
  } sct_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_SUM,
    ST_DIFF,
    ST_LOAD,
    ST_DIV,
    ST_FIN
  } sct_state_t;

endpackage

// ===== sv/sct_sqr.sv =====
module sct_sqr #(
  parameter int MW = 32
) (
  input  logic                 clk,
  input  sct_pkg::sct_ctl_t    ctl,
  input  logic [MW-1:0]        opnd,
  output logic [2*MW-1:0]      square
);
  import sct_pkg::*;

  // Shift-and-add squarer: the multiplier copy shifts out MSB first,
  // one bit per step, and the accumulator doubles before each add.
  logic [MW-1:0]   mcand_r;
  logic [MW-1:0]   mplier_r;
  logic [2*MW-1:0] acc_r;
  logic [2*MW-1:0] acc_nxt;

  always_comb begin
    acc_nxt = {acc_r[2*MW-2:0], 1'b0};
    if (mplier_r[MW-1]) begin
      acc_nxt = acc_nxt + {{MW{1'b0}}, mcand_r};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mcand_r  <= opnd;
      mplier_r <= opnd;
      acc_r    <= '0;
    end else if (ctl.step) begin
      mplier_r <= {mplier_r[MW-2:0], 1'b0};
      acc_r    <= acc_nxt;
    end
  end

  assign square = acc_r;

endmodule

// ===== sv/sct_div.sv =====
module sct_div #(
  parameter int NUMW = 81,
  parameter int DW   = 65
) (
  input  logic                                  clk,
  input  sct_pkg::sct_ctl_t                     ctl,
  input  logic [NUMW-1:0]                       num,
  input  logic [DW-1:0]                         den,
  input  logic                                  neg,
  output logic signed [sct_pkg::OUT_WIDTH-1:0]  result
);
  import sct_pkg::*;

  localparam int HW = NUMW - QUOT_BITS;
  localparam int CW = (HW > DW) ? HW : DW;

  // Restoring division, one quotient bit per step. The part of the
  // numerator above the quotient window seeds the remainder; if it already
  // reaches the divisor, the quotient cannot fit and the result saturates.
  logic                 neg_r;
  logic                 ovf_r;
  logic [DW-1:0]        rem_r;
  logic [QUOT_BITS-1:0] lo_r;
  logic [QUOT_BITS-1:0] quo_r;

  logic [HW-1:0] num_hi;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          qbit;
  logic          sat;

  always_comb begin
    num_hi = num[NUMW-1:QUOT_BITS];
    trial  = {rem_r, lo_r[QUOT_BITS-1]};
    diff   = trial - {1'b0, den};
    qbit   = (trial >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      neg_r <= neg;
      ovf_r <= (CW'(num_hi) >= CW'(den));
      rem_r <= DW'(num_hi);
      lo_r  <= num[QUOT_BITS-1:0];
      quo_r <= '0;
    end else if (ctl.step) begin
      if (qbit) begin
        rem_r <= diff[DW-1:0];
      end else begin
        rem_r <= trial[DW-1:0];
      end
      lo_r  <= {lo_r[QUOT_BITS-2:0], 1'b0};
      quo_r <= {quo_r[QUOT_BITS-2:0], qbit};
    end
  end

  always_comb begin
    sat = ovf_r | quo_r[QUOT_BITS-1];
    if (neg_r) begin
      result = sat ? SAT_NEG : $signed(~quo_r + 1'b1);
    end else begin
      result = sat ? SAT_POS : $signed(quo_r);
    end
  end

endmodule

// ===== sv/sct_track.sv =====
module sct_track (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  upd,
  input  logic                                  last,
  input  logic signed [sct_pkg::OUT_WIDTH-1:0]  value,
  output logic signed [sct_pkg::OUT_WIDTH-1:0]  low_nxt,
  output logic signed [sct_pkg::OUT_WIDTH-1:0]  high_nxt
);
  import sct_pkg::*;

  logic                        have_r;
  logic signed [OUT_WIDTH-1:0] min_r;
  logic signed [OUT_WIDTH-1:0] max_r;

  // The first sample of a vector loads both extremes.
  always_comb begin
    if (!have_r) begin
      low_nxt  = value;
      high_nxt = value;
    end else begin
      low_nxt  = (value < min_r) ? value : min_r;
      high_nxt = (value > max_r) ? value : max_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (upd) begin
      have_r <= !last;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      min_r <= low_nxt;
      max_r <= high_nxt;
    end
  end

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    have_r |-> (min_r <= max_r))
    else $error("running minimum above running maximum");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && last) |=> !have_r)
    else $error("extremes not cleared after the last item of a vector");

endmodule

// ===== sv/smith_chart_transform.sv =====
// One item is in work at a time; the next is accepted only after the last result is
// loaded into the output register. The time is set by the bit-serial squarers
// (SAMPLE_WIDTH steps) and the two radix-2 divider lanes (32 steps), plus the states
// for the sums, the divider load and the output.
// Reset (synchronous, rst_n low) clears the sequencer, the output valid, track_imag
// and the running-extreme flag; there is no clearing pass.
module smith_chart_transform #(
  parameter int RESULT_FRAC_BITS = 28
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sct_pkg::sct_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sct_pkg::sct_out_t  out_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);
  import sct_pkg::*;

  localparam int W   = SAMPLE_WIDTH;
  localparam int F   = W / 2;
  localparam int R   = RESULT_FRAC_BITS;
  // Sums of two squares need one bit more than a square.
  localparam int SW  = 2 * W + 1;
  localparam int NXW = SW + R;
  localparam int NYW = W + F + 1 + R;
  localparam int STEPS_MAX = (W > QUOT_BITS) ? W : QUOT_BITS;
  localparam int CNT_W = $clog2(STEPS_MAX);

  localparam logic [W:0]    T_ONE = {{(W - F){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic [SW-1:0] E_ONE = {{W{1'b0}}, 1'b1, {W{1'b0}}};

  // The block works one item at a time. Accepting an item loads the
  // magnitudes of z_real, z_imag and z_real + 1 into three bit-serial
  // squarers. After the squares are in, the numerator |re^2 + im^2 - 1|
  // and the denominator (re+1)^2 + im^2 are formed in two registered
  // steps, and two divider lanes develop both quotients side by side.
  // The result then waits in the output register while the next item
  // is already being taken in.

  sct_state_t state_r;
  sct_state_t state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  logic     track_imag_r;
  logic     out_valid_r;
  sct_out_t out_r;

  // Per-item context captured when the item is accepted.
  logic         sing_r;
  logic         negy_r;
  logic         last_r;
  logic [W-1:0] bmag_r;

  logic [SW-1:0] p_r;
  logic [SW-1:0] d_r;
  logic [SW-1:0] n_r;
  logic          negx_r;

  logic         in_fire;
  logic         fin_load;
  sct_ctl_t     sqr_ctl;
  sct_ctl_t     div_ctl;

  logic [W:0]   t_full;
  logic [W:0]   tmag_full;
  logic [W-1:0] amag;
  logic [W-1:0] bmag;
  logic [W-1:0] tmag;

  logic [2*W-1:0] a_sq;
  logic [2*W-1:0] b_sq;
  logic [2*W-1:0] t_sq;

  logic [NXW-1:0] num_x;
  logic [NYW-1:0] num_y;
  logic signed [OUT_WIDTH-1:0] gx;
  logic signed [OUT_WIDTH-1:0] gy;
  logic signed [OUT_WIDTH-1:0] gx_fin;
  logic signed [OUT_WIDTH-1:0] gy_fin;
  logic signed [OUT_WIDTH-1:0] tracked;
  logic signed [OUT_WIDTH-1:0] low_nxt;
  logic signed [OUT_WIDTH-1:0] high_nxt;

  // Operand magnitudes. z_real + 1 is one bit wider, but its magnitude
  // always fits the sample width.
  always_comb begin
    t_full    = {in_data.z_real[W-1], in_data.z_real} + T_ONE;
    tmag_full = t_full[W] ? (~t_full + 1'b1) : t_full;
    tmag      = tmag_full[W-1:0];
    amag      = in_data.z_real[W-1] ? (~in_data.z_real + 1'b1) : in_data.z_real;
    bmag      = in_data.z_imag[W-1] ? (~in_data.z_imag + 1'b1) : in_data.z_imag;
  end

  sct_sqr #(.MW(W)) u_sqr_a (
    .clk    (clk),
    .ctl    (sqr_ctl),
    .opnd   (amag),
    .square (a_sq)
  );

  sct_sqr #(.MW(W)) u_sqr_b (
    .clk    (clk),
    .ctl    (sqr_ctl),
    .opnd   (bmag),
    .square (b_sq)
  );

  sct_sqr #(.MW(W)) u_sqr_t (
    .clk    (clk),
    .ctl    (sqr_ctl),
    .opnd   (tmag),
    .square (t_sq)
  );

  // Dividends carry the output scaling: the real part is shifted by the
  // result fraction bits, the imaginary part also by the input fraction
  // bits and one more for the factor of two.
  assign num_x = {n_r, {R{1'b0}}};
  assign num_y = {bmag_r, {(F + 1 + R){1'b0}}};

  sct_div #(.NUMW(NXW), .DW(SW)) u_div_x (
    .clk    (clk),
    .ctl    (div_ctl),
    .num    (num_x),
    .den    (d_r),
    .neg    (negx_r),
    .result (gx)
  );

  sct_div #(.NUMW(NYW), .DW(SW)) u_div_y (
    .clk    (clk),
    .ctl    (div_ctl),
    .num    (num_y),
    .den    (d_r),
    .neg    (negy_r),
    .result (gy)
  );

  // A zero denominator (z equal to minus one) overrides both quotients.
  always_comb begin
    gx_fin  = sing_r ? SAT_POS : gx;
    gy_fin  = sing_r ? '0 : gy;
    tracked = track_imag_r ? gy_fin : gx_fin;
  end

  sct_track u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (fin_load),
    .last     (last_r),
    .value    (tracked),
    .low_nxt  (low_nxt),
    .high_nxt (high_nxt)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: begin
        if (cnt_r == '0) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM:  state_nxt = ST_DIFF;
      ST_DIFF: state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_fire      = 1'b0;
    fin_load     = 1'b0;
    sqr_ctl      = '0;
    div_ctl      = '0;
    cnt_nxt      = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        in_fire      = in_valid;
        sqr_ctl.load = in_valid;
        cnt_nxt      = CNT_W'(W - 1);
      end
      ST_SQR: begin
        sqr_ctl.step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
      end
      ST_SUM, ST_DIFF: begin
        cnt_nxt = cnt_r;
      end
      ST_LOAD: begin
        div_ctl.load = 1'b1;
        cnt_nxt      = CNT_W'(QUOT_BITS - 1);
      end
      ST_DIV: begin
        div_ctl.step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
      end
      ST_FIN: begin
        fin_load = !out_valid_r || !out_stall;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      track_imag_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        track_imag_r <= cfg_wdata;
      end
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    if (in_fire) begin
      sing_r <= (t_full == '0) && (in_data.z_imag == '0);
      negy_r <= in_data.z_imag[W-1];
      last_r <= in_data.last_sample;
      bmag_r <= bmag;
    end
    if (state_r == ST_SUM) begin
      p_r <= {1'b0, a_sq} + {1'b0, b_sq};
      d_r <= {1'b0, t_sq} + {1'b0, b_sq};
    end
    if (state_r == ST_DIFF) begin
      negx_r <= (p_r < E_ONE);
      n_r    <= (p_r < E_ONE) ? (E_ONE - p_r) : (p_r - E_ONE);
    end
    if (fin_load) begin
      out_r.gamma_real    <= gx_fin;
      out_r.gamma_imag    <= gy_fin;
      out_r.low_extreme   <= low_nxt;
      out_r.high_extreme  <= high_nxt;
      out_r.singular      <= sing_r;
      out_r.end_of_vector <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_singular_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.singular) |->
      (out_data.gamma_real == SAT_POS) && (out_data.gamma_imag == '0))
    else $error("singular item without saturated result");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_SQR))
    else $error("accepted item did not start the squarers");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN))
    else $error("result presented outside the finishing step");

endmodule

// ===== verif/tb_smith_chart_transform.sv =====
`timescale 1ns / 100ps

// Checks the Smith-chart transform against its own predictor. The bench drives
// impedance samples through the input channel and works out each reflection
// coefficient exactly, with wide integer arithmetic. It also keeps its own copy of
// the running extremes. Every result from the block is compared field by field
// with the oldest pending prediction.
module tb_smith_chart_transform;
  import sct_pkg::*;

  // The fraction width of the results. It is passed to the block so that the
  // predictor and the RTL always agree on it.
  localparam int RESULT_FRAC = 28;
  localparam int IN_FRAC = SAMPLE_WIDTH / 2;
  // The block's delay from an accepted item to its result with no output stall.
  localparam int LATENCY = SAMPLE_WIDTH + 36;
  // Wide enough for the shifted numerators at the largest sample width.
  localparam int WIDE = 256;
  localparam int UNIT_INT = 1 << IN_FRAC;

  localparam bit TRACK_REAL = 1'b0;
  localparam bit TRACK_IMAG = 1'b1;

  localparam logic signed [SAMPLE_WIDTH-1:0] UNIT = UNIT_INT;
  localparam logic signed [SAMPLE_WIDTH-1:0] MAX_S = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] MIN_S = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  sct_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  sct_out_t out_data;
  logic     cfg_we;
  logic     cfg_wdata;

  // This is the predictor's copy of the block state. It is updated at the edge
  // where an item or a register write is accepted.
  bit                          track_sel = TRACK_REAL;
  bit                          vector_open = 1'b0;
  logic signed [OUT_WIDTH-1:0] vec_low;
  logic signed [OUT_WIDTH-1:0] vec_high;

  sct_out_t pending_gamma[$];
  int       items_sent = 0;
  int       results_seen = 0;
  int       fail_count = 0;

  // The sender and the receiver read these controls. When pace_on is set, both
  // sides idle in random bursts. A nonzero hold_cycles makes the receiver hold
  // off for that many cycles in one stretch.
  bit pace_on = 1'b0;
  int hold_cycles = 0;

  smith_chart_transform #(
    .RESULT_FRAC_BITS(RESULT_FRAC)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // A quotient magnitude becomes a signed result. The result saturates once
  // the magnitude reaches 2^(OUT_WIDTH-1), in either sign.
  function automatic logic signed [OUT_WIDTH-1:0] clamp_quotient(logic [WIDE-1:0] mag,
                                                                  bit neg);
    logic [WIDE-1:0]      limit;
    logic [OUT_WIDTH-1:0] low_bits;
    limit = '0;
    limit[OUT_WIDTH-1] = 1'b1;
    low_bits = mag[OUT_WIDTH-1:0];
    if (mag >= limit) return neg ? SAT_NEG : SAT_POS;
    return neg ? -low_bits : low_bits;
  endfunction

  // This computes gamma = (z - 1) / (z + 1) from the raw fixed-point parts. Both
  // quotients are truncated toward zero. The function then moves the running
  // extremes on.
  function automatic sct_out_t predict_reflection(sct_in_t sample);
    logic signed [WIDE-1:0]      re_s, im_s, sh_s, unit_w;
    logic [WIDE-1:0]             re_m, im_m, sh_m, power, denom, unity, numer;
    logic signed [OUT_WIDTH-1:0] gx, gy, tracked;
    bit                          neg_x, sing;
    sct_out_t                    res;
    re_s = WIDE'($signed(sample.z_real));
    im_s = WIDE'($signed(sample.z_imag));
    unit_w = '0;
    unit_w[IN_FRAC] = 1'b1;
    sh_s = re_s + unit_w;
    re_m = (re_s < 0) ? -re_s : re_s;
    im_m = (im_s < 0) ? -im_s : im_s;
    sh_m = (sh_s < 0) ? -sh_s : sh_s;
    power = re_m * re_m + im_m * im_m;
    denom = sh_m * sh_m + im_m * im_m;
    unity = '0;
    unity[2*IN_FRAC] = 1'b1;
    sing = (sh_s == 0) && (im_s == 0);
    if (sing) begin
      // The denominator is zero only at z = -1. The block then reports the
      // largest positive real part and a zero imaginary part.
      gx = SAT_POS;
      gy = '0;
    end else begin
      if (power >= unity) begin
        numer = power - unity;
        neg_x = 1'b0;
      end else begin
        numer = unity - power;
        neg_x = 1'b1;
      end
      gx = clamp_quotient((numer << RESULT_FRAC) / denom, neg_x);
      gy = clamp_quotient((im_m << (IN_FRAC + 1 + RESULT_FRAC)) / denom, im_s < 0);
    end

    // The first sample of a vector loads both extremes. If the tracked part
    // changes inside a vector, the new part is compared against the old extremes.
    tracked = (track_sel == TRACK_IMAG) ? gy : gx;
    if (!vector_open) begin
      vec_low = tracked;
      vec_high = tracked;
    end else begin
      if (tracked < vec_low) vec_low = tracked;
      if (tracked > vec_high) vec_high = tracked;
    end
    vector_open = !sample.last_sample;

    res.gamma_real = gx;
    res.gamma_imag = gy;
    res.low_extreme = vec_low;
    res.high_extreme = vec_high;
    res.singular = sing;
    res.end_of_vector = sample.last_sample;
    return res;
  endfunction

  function automatic sct_in_t impedance(logic signed [SAMPLE_WIDTH-1:0] re,
                                        logic signed [SAMPLE_WIDTH-1:0] im, bit last);
    sct_in_t s;
    s.z_real = re;
    s.z_imag = im;
    s.last_sample = last;
    return s;
  endfunction

  // The random samples are a mix. The largest share are full-range values, which toggle
  // every bit. Many lie within four units of zero in both parts. The rest are real-only
  // samples, samples with a tiny imaginary part, and samples close to or exactly at the singular point.
  function automatic sct_in_t random_impedance();
    sct_in_t     s;
    logic [63:0] raw_re, raw_im;
    int          pick;
    raw_re = {$urandom, $urandom};
    raw_im = {$urandom, $urandom};
    s.z_real = raw_re[SAMPLE_WIDTH-1:0];
    s.z_imag = raw_im[SAMPLE_WIDTH-1:0];
    s.last_sample = 1'b0;
    pick = $urandom_range(0, 19);
    case (pick)
      7, 8, 9, 10, 11, 12: begin
        s.z_real = int'($urandom_range(0, 8 * UNIT_INT)) - 4 * UNIT_INT;
        s.z_imag = int'($urandom_range(0, 8 * UNIT_INT)) - 4 * UNIT_INT;
      end
      13, 14: begin
        s.z_real = int'($urandom_range(0, 8 * UNIT_INT)) - 4 * UNIT_INT;
        s.z_imag = '0;
      end
      15: s.z_imag = '0;
      16, 17: begin
        s.z_real = -UNIT_INT + int'($urandom_range(0, 64)) - 32;
        s.z_imag = int'($urandom_range(0, 64)) - 32;
      end
      18: begin
        s.z_real = -UNIT_INT;
        s.z_imag = '0;
      end
      19: s.z_imag = int'($urandom_range(0, 16)) - 8;
      default: ;
    endcase
    return s;
  endfunction

  // This task offers one item and returns at the edge where the block takes it.
  // Valid stays high after the item is taken, so that back-to-back items keep it
  // high without a glitch. Valid is lowered only at the start of a gap or by
  // wait_drained.
  task automatic send_sample(input sct_in_t sample);
    int gap;
    if (pace_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_gamma.push_back(predict_reflection(sample));
    items_sent++;
  endtask

  // Every item gives exactly one result. Once nothing is pending, the block is
  // therefore idle and a register write is safe.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_gamma.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_track(input bit sel);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= sel;
    @(posedge clk);
    cfg_we <= 1'b0;
    track_sel = sel;
  endtask

  task automatic send_random_vector();
    sct_in_t s;
    int      len;
    len = $urandom_range(1, 16);
    for (int k = 0; k < len; k++) begin
      s = random_impedance();
      s.last_sample = (k == len - 1);
      send_sample(s);
    end
  endtask

  // The directed items run on the reset value of the register, which tracks the
  // real part. They cover zero, unity, the singular point and its neighbors on
  // both sides, and the extremes of both parts. They include a vector of one
  // sample and a singular sample inside a vector.
  task automatic test_directed_corners();
    send_sample(impedance('0, '0, 1'b0));
    send_sample(impedance(UNIT, '0, 1'b0));
    send_sample(impedance(-UNIT, '0, 1'b0));
    send_sample(impedance(-UNIT + 1, '0, 1'b0));
    send_sample(impedance(-UNIT - 1, '0, 1'b0));
    send_sample(impedance(-UNIT, 1, 1'b0));
    send_sample(impedance(-UNIT, -1, 1'b1));
    send_sample(impedance(MAX_S, MAX_S, 1'b1));
    send_sample(impedance(MIN_S, MIN_S, 1'b0));
    send_sample(impedance(MIN_S, '0, 1'b0));
    send_sample(impedance('0, MIN_S, 1'b0));
    send_sample(impedance('0, MAX_S, 1'b0));
    send_sample(impedance(UNIT, UNIT, 1'b0));
    send_sample(impedance(UNIT, -UNIT, 1'b1));
  endtask

  // This test tracks the imaginary part, and then switches back to the real part
  // in the middle of a vector.
  task automatic test_tracking_switch();
    write_track(TRACK_IMAG);
    send_sample(impedance(UNIT, UNIT, 1'b0));
    send_sample(impedance(-UNIT, '0, 1'b0));
    send_sample(impedance('0, -2 * UNIT, 1'b0));
    write_track(TRACK_REAL);
    send_sample(impedance(3 * UNIT, '0, 1'b0));
    send_sample(impedance(MAX_S, 1, 1'b0));
    send_sample(impedance(MIN_S, MAX_S, 1'b1));
  endtask

  // Both sides idle at random here. Between the phases the register is rewritten
  // while the block is idle.
  task automatic test_random_vectors();
    bit phase_track[6] = '{TRACK_REAL, TRACK_IMAG, TRACK_IMAG,
                           TRACK_REAL, TRACK_IMAG, TRACK_REAL};
    int target;
    pace_on = 1'b1;
    foreach (phase_track[p]) begin
      write_track(phase_track[p]);
      target = items_sent + 260;
      while (items_sent < target) send_random_vector();
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // items. One item is in work, so the input stalls soon. The sender then
  // pauses until every pending result has come back.
  task automatic test_output_hold();
    sct_in_t s;
    hold_cycles = 400;
    for (int k = 0; k < 6; k++) begin
      s = random_impedance();
      s.last_sample = (k == 5);
      send_sample(s);
    end
    wait_drained();
  endtask

  task automatic test_unpaced_stream();
    int target;
    pace_on = 1'b0;
    write_track(TRACK_IMAG);
    target = items_sent + 180;
    while (items_sent < target) send_random_vector();
  endtask

  // The receiver holds out_stall high for random bursts, or for one long
  // stretch when a test asks for it. The stretch is counted here.
  initial begin : receiver_pace
    int span;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        span = hold_cycles;
        hold_cycles = 0;
        out_stall <= 1'b1;
        repeat (span) @(posedge clk);
        out_stall <= 1'b0;
      end else if (pace_on && $urandom_range(0, 5) == 0) begin
        span = $urandom_range(1, 13);
        out_stall <= 1'b1;
        repeat (span) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void compare_field(string field, logic [OUT_WIDTH-1:0] want,
                                        logic [OUT_WIDTH-1:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("result %0d %s: expected %0d (%h) got %0d (%h)", results_seen, field,
                 $signed(want), want, $signed(got), got);
    end
  endfunction

  // Signals are sampled at the rising edge, which gives their values before
  // the edge. A result is taken when valid is high and stall is low.
  always @(posedge clk) begin : result_check
    sct_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_gamma.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("result %0d arrived with nothing pending: %h", results_seen, out_data);
      end else begin
        want = pending_gamma.pop_front();
        compare_field("gamma_real", want.gamma_real, out_data.gamma_real);
        compare_field("gamma_imag", want.gamma_imag, out_data.gamma_imag);
        compare_field("low_extreme", want.low_extreme, out_data.low_extreme);
        compare_field("high_extreme", want.high_extreme, out_data.high_extreme);
        compare_field("singular", OUT_WIDTH'(want.singular),
                      OUT_WIDTH'(out_data.singular));
        compare_field("end_of_vector", OUT_WIDTH'(want.end_of_vector),
                      OUT_WIDTH'(out_data.end_of_vector));
      end
      results_seen++;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    test_tracking_switch();
    test_random_vectors();
    test_output_hold();
    test_unpaced_stream();

    wait_drained();
    repeat (LATENCY + 8) @(posedge clk);
    if (fail_count == 0 && pending_gamma.size() == 0)
      $display("tb_smith_chart_transform passed");
    else
      $display("tb_smith_chart_transform failed");
    $finish;
  end

  // The time limit is several times the slowest correct run, in which every item waits
  // out the longest gap and the longest stall on top of the block's own processing.
  initial begin
    #8_000_000;
    $display("tb_smith_chart_transform failed");
    $finish;
  end

endmodule
